@@ rtl/dda_pkg.sv @@
// dda_pkg: shared widths, config register codes and control structs
// for the dda line rasterizer; no dependencies
package dda_pkg;

	localparam int COORD_W  = 16;  // unsigned q8.8 map coordinate
	localparam int COLOR_W  = 24;
	localparam int PIX_W    = 15;  // screen coordinate
	localparam int SCALE_W  = 7;
	localparam int OFFSET_W = 10;
	localparam int BOUND_W  = 12;
	localparam int MAG_W    = COORD_W + SCALE_W;  // scaled span magnitude, q.8
	localparam int STEP_W   = MAG_W - 8;          // integer part of the span
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int MAX_STEPS_DEF = 63;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

	localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(8);
	localparam logic [OFFSET_W-1:0] OFFSET_RST = '0;
	localparam logic [BOUND_W-1:0]  WIDTH_RST  = BOUND_W'(1024);
	localparam logic [BOUND_W-1:0]  HEIGHT_RST = BOUND_W'(768);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TILE_SCALE    = 3'd0,
		CFG_PIXEL_OFFSET  = 3'd1,
		CFG_SCREEN_WIDTH  = 3'd2,
		CFG_SCREEN_HEIGHT = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [SCALE_W-1:0]  tile_scale;
		logic [OFFSET_W-1:0] pixel_offset;
		logic [BOUND_W-1:0]  screen_width;
		logic [BOUND_W-1:0]  screen_height;
	} dda_cfg_t;

	typedef struct packed {
		logic load_in;   // input transfer
		logic setup;     // scale spans and start points
		logic prep;      // step count, divider and accumulator init
		logic div_step;  // one quotient bit per axis
		logic emit;      // load one pixel into the output register
	} dda_cmd_t;

	typedef struct packed {
		logic steps_zero;
		logic emit_last;
	} dda_sts_t;

endpackage

@@ rtl/dda_regs.sv @@
// dda_regs: configuration registers of the line rasterizer
// depends on dda_pkg
module dda_regs
	import dda_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output dda_cfg_t              cfg
);

	dda_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tile_scale    <= SCALE_RST;
			cfg_q.pixel_offset  <= OFFSET_RST;
			cfg_q.screen_width  <= WIDTH_RST;
			cfg_q.screen_height <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TILE_SCALE:    cfg_q.tile_scale    <= cfg_data[SCALE_W-1:0];
				CFG_PIXEL_OFFSET:  cfg_q.pixel_offset  <= cfg_data[OFFSET_W-1:0];
				CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data[BOUND_W-1:0];
				CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/dda_ctrl.sv @@
// dda_ctrl: sequencer for setup, increment division and pixel emission
// depends on dda_pkg
module dda_ctrl
	import dda_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dda_sts_t sts,
	output dda_cmd_t cmd
);

	localparam int DCW = $clog2(FRAC_BITS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_PREP,
		S_DIV,
		S_EMIT
	} state_t;

	state_t         state_q;
	logic [DCW-1:0] div_cnt_q;
	logic           out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == S_IDLE) && in_valid;
		cmd.setup    = (state_q == S_SETUP);
		cmd.prep     = (state_q == S_PREP);
		cmd.div_step = (state_q == S_DIV);
		cmd.emit     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SETUP;
				end
				S_SETUP: state_q <= S_PREP;
				S_PREP: begin
					div_cnt_q <= '0;
					// a span below one pixel produces no output
					state_q   <= sts.steps_zero ? S_IDLE : S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCW'(FRAC_BITS))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (cmd.emit && sts.emit_last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

@@ rtl/dda_datapath.sv @@
// dda_datapath: span scaling, restoring dividers, accumulators and output register
// depends on dda_pkg
module dda_datapath
	import dda_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dda_cmd_t           cmd,
	output dda_sts_t           sts,
	input  dda_cfg_t           cfg,
	input  logic [COORD_W-1:0] start_x,
	input  logic [COORD_W-1:0] start_y,
	input  logic [COORD_W-1:0] end_x,
	input  logic [COORD_W-1:0] end_y,
	input  logic [COLOR_W-1:0] pixel_color,
	output logic [PIX_W-1:0]   pixel_x,
	output logic [PIX_W-1:0]   pixel_y,
	output logic [COLOR_W-1:0] out_color,
	output logic               on_screen,
	output logic               last_pixel,
	output logic               truncated
);

	localparam int QW = FRAC_BITS + 1;      // quotient bits: increment < 2^(FRAC_BITS+1)
	localparam int AW = FRAC_BITS + 18;     // signed accumulator
	localparam int IPW = AW - 1 - FRAC_BITS;
	localparam int CW = $clog2(MAX_STEPS + 2);

	// input hold
	logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
	logic [COLOR_W-1:0] color_q;

	// setup results
	logic [MAG_W-1:0] magx_q, magy_q, prodx_q, prody_q;
	logic             negx_q, negy_q;

	// divider and walk state
	logic [STEP_W-1:0]   steps_q;
	logic [STEP_W-1:0]   remx_q, remy_q;
	logic [QW-1:0]       shx_q, shy_q;
	logic signed [AW-1:0] accx_q, accy_q;
	logic [CW-1:0]       steps_left_q;
	logic                cut_q;

	// output register
	logic [PIX_W-1:0]   px_q, py_q;
	logic [COLOR_W-1:0] ocolor_q;
	logic               onscr_q, last_q, trunc_q;

	// span differences and magnitudes
	logic [COORD_W:0]   dx, dy;
	logic [COORD_W-1:0] adx, ady;
	always_comb begin
		dx  = {1'b0, ex_q} - {1'b0, sx_q};
		dy  = {1'b0, ey_q} - {1'b0, sy_q};
		adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
		ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
	end

	logic [MAG_W-1:0]  mag_max;
	logic [STEP_W-1:0] steps;
	logic              cut;
	logic [CW-1:0]     count;
	always_comb begin
		mag_max = (magx_q >= magy_q) ? magx_q : magy_q;
		steps   = mag_max[MAG_W-1:8];
		cut     = steps > STEP_W'(MAX_STEPS);
		count   = cut ? CW'(MAX_STEPS + 1) : CW'(steps) + 1'b1;
	end

	// one restoring step per axis
	logic [STEP_W:0]   tx, ty, dfx, dfy;
	logic              gex, gey;
	always_comb begin
		tx  = {remx_q, shx_q[QW-1]};
		ty  = {remy_q, shy_q[QW-1]};
		dfx = tx - {1'b0, steps_q};
		dfy = ty - {1'b0, steps_q};
		gex = tx >= {1'b0, steps_q};
		gey = ty >= {1'b0, steps_q};
	end

	function automatic logic [PIX_W-1:0] coord_of(input logic signed [AW-1:0] acc);
		logic [IPW-1:0] ip;
		ip = acc[AW-2:FRAC_BITS];
		if (acc[AW-1])
			coord_of = '0;
		else if (ip > IPW'(PIX_MAX))
			coord_of = PIX_MAX;
		else
			coord_of = ip[PIX_W-1:0];
	endfunction

	logic [PIX_W-1:0] cx, cy;
	logic [AW-1:0]    incx, incy;
	always_comb begin
		cx   = coord_of(accx_q);
		cy   = coord_of(accy_q);
		incx = AW'(shx_q);
		incy = AW'(shy_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sx_q    <= start_x;
			sy_q    <= start_y;
			ex_q    <= end_x;
			ey_q    <= end_y;
			color_q <= pixel_color;
		end
		if (cmd.setup) begin
			magx_q  <= MAG_W'(adx) * MAG_W'(cfg.tile_scale);
			magy_q  <= MAG_W'(ady) * MAG_W'(cfg.tile_scale);
			negx_q  <= dx[COORD_W];
			negy_q  <= dy[COORD_W];
			prodx_q <= MAG_W'(sx_q) * MAG_W'(cfg.tile_scale);
			prody_q <= MAG_W'(sy_q) * MAG_W'(cfg.tile_scale);
		end
		if (cmd.prep) begin
			steps_q <= steps;
			cut_q   <= cut;
			// quotient fits in QW bits, so the dividend bits above it seed the remainder
			remx_q  <= STEP_W'(magx_q[MAG_W-1:9]);
			remy_q  <= STEP_W'(magy_q[MAG_W-1:9]);
			shx_q   <= QW'(magx_q[8:0]) << (FRAC_BITS - 8);
			shy_q   <= QW'(magy_q[8:0]) << (FRAC_BITS - 8);
			accx_q  <= $signed((AW'(prodx_q) << (FRAC_BITS - 8))
				+ (AW'(cfg.pixel_offset) << FRAC_BITS));
			accy_q  <= $signed((AW'(prody_q) << (FRAC_BITS - 8))
				+ (AW'(cfg.pixel_offset) << FRAC_BITS));
		end
		if (cmd.div_step) begin
			remx_q <= gex ? dfx[STEP_W-1:0] : tx[STEP_W-1:0];
			remy_q <= gey ? dfy[STEP_W-1:0] : ty[STEP_W-1:0];
			shx_q  <= {shx_q[QW-2:0], gex};
			shy_q  <= {shy_q[QW-2:0], gey};
		end
		if (cmd.emit) begin
			px_q     <= cx;
			py_q     <= cy;
			ocolor_q <= color_q;
			onscr_q  <= (cx < PIX_W'(cfg.screen_width)) && (cy < PIX_W'(cfg.screen_height));
			last_q   <= (steps_left_q == CW'(1));
			trunc_q  <= (steps_left_q == CW'(1)) && cut_q;
			accx_q   <= negx_q ? accx_q - $signed(incx) : accx_q + $signed(incx);
			accy_q   <= negy_q ? accy_q - $signed(incy) : accy_q + $signed(incy);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			steps_left_q <= '0;
		else if (cmd.prep)
			steps_left_q <= count;
		else if (cmd.emit)
			steps_left_q <= steps_left_q - 1'b1;
	end

	always_comb begin
		sts            = '0;
		sts.steps_zero = (steps == '0);
		sts.emit_last  = (steps_left_q == CW'(1));
	end

	assign pixel_x    = px_q;
	assign pixel_y    = py_q;
	assign out_color  = ocolor_q;
	assign on_screen  = onscr_q;
	assign last_pixel = last_q;
	assign truncated  = trunc_q;

endmodule

@@ rtl/dda_line_rasterizer.sv @@
// dda_line_rasterizer: top level, dda line walker for a minimap
// depends on dda_pkg, dda_regs, dda_ctrl, dda_datapath
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------------
//  in       | in_valid / in_stall   | start_x start_y end_x end_y pixel_color
//  out      | out_valid / out_stall | pixel_x pixel_y out_color on_screen last_pixel
//           |                       | truncated
//  cfg      | cfg_we                | cfg_index cfg_data
//
// a line passes the setup and prep states, then bit-serial division
// (restoring dividers, one per axis), then the emit state, which loads
// one pixel per cycle while out_stall is low.
// a line shorter than one pixel ends after the prep state with no output.
// out_stall holds the walker on the current pixel; the next line is taken
// once the last pixel is in the output register.
// arst_n clears the sequencer and restores the config defaults.
module dda_line_rasterizer
	import dda_pkg::*;
#(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_W-1:0]    start_x,
	input  logic [COORD_W-1:0]    start_y,
	input  logic [COORD_W-1:0]    end_x,
	input  logic [COORD_W-1:0]    end_y,
	input  logic [COLOR_W-1:0]    pixel_color,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PIX_W-1:0]      pixel_x,
	output logic [PIX_W-1:0]      pixel_y,
	output logic [COLOR_W-1:0]    out_color,
	output logic                  on_screen,
	output logic                  last_pixel,
	output logic                  truncated
);

	dda_cfg_t cfg;
	dda_cmd_t cmd;
	dda_sts_t sts;

	dda_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dda_ctrl #(
		.FRAC_BITS (FRAC_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	dda_datapath #(
		.MAX_STEPS (MAX_STEPS),
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.pixel_color (pixel_color),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.out_color   (out_color),
		.on_screen   (on_screen),
		.last_pixel  (last_pixel),
		.truncated   (truncated)
	);

	// a new line is never taken while one is being set up
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while the walker was busy");

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!truncated || last_pixel))
		else $error("truncated flag on a pixel that is not the last");

	// pixels of one line follow back to back once the divide is done
	a_no_gap_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last_pixel) |=> out_valid)
		else $error("gap between pixels of one line");

endmodule

@@ dv/tb_dda_line_rasterizer.sv @@
// tb_dda_line_rasterizer: self-checking testbench for the dda line rasterizer,
// predicts every pixel of each accepted line and checks it against the output channel
// depends on dda_pkg and dda_line_rasterizer
module tb_dda_line_rasterizer
	import dda_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_STEPS    = MAX_STEPS_DEF;
	localparam int FRAC_BITS    = FRAC_BITS_DEF;
	localparam int QUIET_CYCLES = 120;  // a full line plus margin
	localparam int UNUSED_IDX   = CFG_SCREEN_HEIGHT + 1;

	typedef longint unsigned u64_t;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic [COORD_W-1:0] ex;
		logic [COORD_W-1:0] ey;
		logic [COLOR_W-1:0] color;
		bit                 drain_first;  // hold off until all pixels are out
	} line_t;

	typedef struct packed {
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic [COLOR_W-1:0] color;
		logic               on;
		logic               last;
		logic               cut;
	} pixel_t;

	logic                  clk;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic [COORD_W-1:0]    start_x     = '0;
	logic [COORD_W-1:0]    start_y     = '0;
	logic [COORD_W-1:0]    end_x       = '0;
	logic [COORD_W-1:0]    end_y       = '0;
	logic [COLOR_W-1:0]    pixel_color = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic [PIX_W-1:0]      pixel_x;
	logic [PIX_W-1:0]      pixel_y;
	logic [COLOR_W-1:0]    out_color;
	logic                  on_screen;
	logic                  last_pixel;
	logic                  truncated;

	dda_cfg_t cfg_shadow = '{SCALE_RST, OFFSET_RST, WIDTH_RST, HEIGHT_RST};
	line_t    line_q[$];
	pixel_t   pixel_q[$];
	int       error_count = 0;
	bit       steady = 1'b0;

	dda_line_rasterizer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.pixel_color(pixel_color),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .out_color(out_color),
		.on_screen(on_screen), .last_pixel(last_pixel), .truncated(truncated)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb_dda_line_rasterizer: FAIL");
		$finish;
	end

	function automatic bit take_break();
		return !steady && ($urandom_range(99) < 14);
	endfunction

	function automatic void flag_error(string msg);
		error_count++;
		if (error_count <= 10)
			$display("%t: %s", $realtime, msg);
	endfunction

	function automatic logic [PIX_W-1:0] screen_coord(longint acc);
		if (acc < 0)
			return '0;
		if ((acc >>> FRAC_BITS) > PIX_MAX)
			return PIX_MAX;
		return PIX_W'(acc >>> FRAC_BITS);
	endfunction

	// expected pixels of one line under the current register values
	function automatic void trace_line(line_t l);
		longint dx, dy, x_acc, y_acc, x_inc, y_inc;
		u64_t   adx, ady, steps, count;
		bit     cut;
		pixel_t p;
		dx = (longint'(l.ex) - longint'(l.sx)) * longint'(cfg_shadow.tile_scale);
		dy = (longint'(l.ey) - longint'(l.sy)) * longint'(cfg_shadow.tile_scale);
		adx = dx < 0 ? u64_t'(-dx) : u64_t'(dx);
		ady = dy < 0 ? u64_t'(-dy) : u64_t'(dy);
		steps = (adx > ady ? adx : ady) >> 8;
		if (steps == 0)
			return;
		// span is q.8, increment keeps FRAC_BITS fraction bits, truncated toward zero
		x_inc = longint'((adx << (FRAC_BITS - 8)) / steps);
		y_inc = longint'((ady << (FRAC_BITS - 8)) / steps);
		if (dx < 0)
			x_inc = -x_inc;
		if (dy < 0)
			y_inc = -y_inc;
		x_acc = longint'(((u64_t'(l.sx) * cfg_shadow.tile_scale) << (FRAC_BITS - 8))
			+ (u64_t'(cfg_shadow.pixel_offset) << FRAC_BITS));
		y_acc = longint'(((u64_t'(l.sy) * cfg_shadow.tile_scale) << (FRAC_BITS - 8))
			+ (u64_t'(cfg_shadow.pixel_offset) << FRAC_BITS));
		cut = steps > MAX_STEPS;
		count = cut ? MAX_STEPS + 1 : steps + 1;
		for (u64_t k = 0; k < count; k++) begin
			p.px    = screen_coord(x_acc);
			p.py    = screen_coord(y_acc);
			p.color = l.color;
			p.on    = p.px < cfg_shadow.screen_width && p.py < cfg_shadow.screen_height;
			p.last  = k + 1 == count;
			p.cut   = p.last && cut;
			pixel_q.push_back(p);
			x_acc += x_inc;
			y_acc += y_inc;
		end
	endfunction

	// sender: holds a stalled transfer, otherwise offers the next pending line
	always @(posedge clk) begin
		line_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall)
				trace_line(line_q.pop_front());
			if (!in_valid || !in_stall) begin
				if (line_q.size() != 0 && !take_break()
						&& (!line_q[0].drain_first || pixel_q.size() == 0)) begin
					nxt = line_q[0];
					in_valid    <= 1'b1;
					start_x     <= nxt.sx;
					start_y     <= nxt.sy;
					end_x       <= nxt.ex;
					end_y       <= nxt.ey;
					pixel_color <= nxt.color;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks every pixel transfer against the oldest expected pixel
	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {pixel_x, pixel_y, out_color, on_screen, last_pixel, truncated};
				if (pixel_q.size() == 0) begin
					flag_error($sformatf("unexpected pixel (%0d,%0d) color %06h",
						pixel_x, pixel_y, out_color));
				end else begin
					want = pixel_q.pop_front();
					if (got !== want)
						flag_error($sformatf({"pixel mismatch: expected (%0d,%0d) %06h on %0b ",
							"last %0b cut %0b, got (%0d,%0d) %06h on %0b last %0b cut %0b"},
							want.px, want.py, want.color, want.on, want.last, want.cut,
							got.px, got.py, got.color, got.on, got.last, got.cut));
				end
			end
			out_stall <= take_break();
		end
	end

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_TILE_SCALE:    cfg_shadow.tile_scale    = val[SCALE_W-1:0];
			CFG_PIXEL_OFFSET:  cfg_shadow.pixel_offset  = val[OFFSET_W-1:0];
			CFG_SCREEN_WIDTH:  cfg_shadow.screen_width  = val[BOUND_W-1:0];
			CFG_SCREEN_HEIGHT: cfg_shadow.screen_height = val[BOUND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(int scale, int offset, int width, int height);
		set_reg(CFG_TILE_SCALE, CFG_DATA_W'(scale));
		set_reg(CFG_PIXEL_OFFSET, CFG_DATA_W'(offset));
		set_reg(CFG_SCREEN_WIDTH, CFG_DATA_W'(width));
		set_reg(CFG_SCREEN_HEIGHT, CFG_DATA_W'(height));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for all lines and pixels, then let a line with no pixels finish too
	task automatic settle();
		while (line_q.size() != 0 || pixel_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic push_line(int sx, int sy, int ex, int ey, int color, bit drain = 1'b0);
		line_t l;
		l.sx = COORD_W'(sx);
		l.sy = COORD_W'(sy);
		l.ex = COORD_W'(ex);
		l.ey = COORD_W'(ey);
		l.color = COLOR_W'(color);
		l.drain_first = drain;
		line_q.push_back(l);
	endtask

	// end point at the given offset, mirrored when it falls off the map
	function automatic int reach(int from, int d);
		int e;
		e = from + d;
		if (e > 65535 || e < 0)
			e = from - d;
		return e < 0 ? 0 : (e > 65535 ? 65535 : e);
	endfunction

	task automatic add_random_lines(int n);
		int sc, mode, sx, sy, dx, dy;
		sc = cfg_shadow.tile_scale == 0 ? 1 : cfg_shadow.tile_scale;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(99);
			sx = $urandom_range(65535);
			sy = $urandom_range(65535);
			// span in map units giving about 0..70 pixel steps at this scale
			dx = ($urandom_range(70) * 256 + $urandom_range(255)) / sc;
			dy = $urandom_range(dx);
			if (mode < 20) begin
				push_line(sx, sy, $urandom_range(65535), $urandom_range(65535),
					$urandom, i == n / 2);
				continue;
			end else if (mode < 70) begin
				if ($urandom_range(1))
					{dx, dy} = {dy, dx};
			end else if (mode < 85) begin
				case ($urandom_range(2))
					0: dy = 0;
					1: begin dy = dx; dx = 0; end
					default: dy = dx;
				endcase
			end else begin
				// right around the one-pixel threshold
				dx = 256 / sc + $urandom_range(2) - 1;
				dy = $urandom_range(dx);
			end
			if ($urandom_range(1))
				dx = -dx;
			if ($urandom_range(1))
				dy = -dy;
			push_line(sx, sy, reach(sx, dx), reach(sy, dy), $urandom, i == n / 2);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: scale 8, so 32 map units per pixel
		push_line(100, 100, 100, 100, 'h123456);
		push_line(0, 0, 31, 0, 'h654321);
		push_line(0, 0, 32, 0, 'hABCDEF);
		push_line('h1000, 'h2000, 'h1400, 'h2000, 'h0000FF);
		push_line('h1400, 'h2000, 'h1000, 'h2000, 'h00FF00);
		push_line('h3000, 'h1000, 'h3000, 'h1600, 'hFF0000);
		push_line('h3000, 'h1600, 'h3000, 'h1000, 'h808080, 1'b1);
		push_line('h0800, 'h0800, 'h0A00, 'h0A00, 'h7F7F7F);
		push_line('h0A00, 'h0800, 'h0800, 'h0A00, 'h010101);
		push_line(0, 100, 2016, 100, 'h55AA55);
		push_line(2048, 100, 0, 100, 'hAA55AA);
		push_line(0, 0, 65535, 65535, 'hFFFFFF);
		push_line(65535, 65535, 0, 0, 'h000000);
		push_line(65535, 0, 64535, 1000, 'h0F0F0F);
		push_line(32640, 24480, 32960, 24600, 'hF0F0F0);
		push_line('h00FF, 'h0180, 'h03AB, 'h0291, 'h3C3C3C);
		push_line(500, 65535, 700, 65535 - 3000, 'hC3C3C3);
		settle();

		// scale written with junk above its width
		apply_config('hF81, 0, 4095, 4095);
		add_random_lines(45);
		settle();

		steady = 1'b1;
		apply_config(64, 1023, 1, 1);
		add_random_lines(45);
		settle();
		steady = 1'b0;

		// scaled start beyond 15 bits saturates
		apply_config(127, 1023, 4095, 4095);
		push_line(65535, 65535, 65535 - 600, 65535 - 300, 'h112233);
		add_random_lines(40);
		settle();

		apply_config(0, 512, 0, 4095);
		add_random_lines(10);
		settle();

		apply_config(16, 3, 4095, 0);
		add_random_lines(20);
		settle();

		for (int ph = 0; ph < 3; ph++) begin
			set_reg(CFG_IDX_W'(UNUSED_IDX + $urandom_range(CFG_IDX_W'('1) - UNUSED_IDX)),
				CFG_DATA_W'($urandom));
			apply_config($urandom_range(1, 64), $urandom_range(1023),
				$urandom_range(1, 4095), $urandom_range(1, 4095));
			add_random_lines(35);
			settle();
		end

		if (error_count == 0)
			$display("tb_dda_line_rasterizer: PASS");
		else
			$display("tb_dda_line_rasterizer: FAIL");
		$finish;
	end

endmodule
